@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL files of the magnetometer calibrator.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define MMC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define MMC_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

@@ hw/rtl/mmc_pkg.sv @@
// Package for the magnetometer min/max calibrator: widths, codes, types.
// No dependencies; used by the interfaces, the divider, the sequencer and the top level.
package mmc_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int SCALE_FRAC_BITS = 12;

    localparam int AXES      = 3;
    localparam int AXIS_W    = $clog2(AXES);
    localparam int SCALE_W   = SCALE_FRAC_BITS + 4;
    localparam int DIFF_W    = SAMPLE_BITS + 1;
    localparam int HALF_W    = SAMPLE_BITS - 1;
    localparam int SUM_W     = HALF_W + 2;
    localparam int DIVIDEND_W = SUM_W + SCALE_FRAC_BITS;
    localparam int DIVISOR_W = HALF_W + 2;
    localparam int QUO_W     = DIVIDEND_W;
    localparam int CNT_W     = $clog2(QUO_W);
    localparam int PROD_W    = DIFF_W + SCALE_W + 1;
    localparam int SHR_W     = PROD_W - SCALE_FRAC_BITS;
    localparam int CMD_W     = 3;
    localparam int STATUS_W  = 2;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic        [HALF_W-1:0]      half_t;
    typedef logic        [SUM_W-1:0]       sum_t;
    typedef logic        [SCALE_W-1:0]     scale_t;
    typedef logic signed [SCALE_W:0]       sscale_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [SHR_W-1:0]       shr_t;
    typedef logic        [DIVIDEND_W-1:0]  dividend_t;
    typedef logic        [DIVISOR_W-1:0]   divisor_t;
    typedef logic        [QUO_W-1:0]       quo_t;
    typedef logic        [AXIS_W-1:0]      axis_t;

    localparam axis_t  AXIS_FIRST = '0;
    localparam axis_t  AXIS_LAST  = AXIS_W'(AXES - 1);
    localparam scale_t SCALE_ONE  = scale_t'(1 << SCALE_FRAC_BITS);
    localparam scale_t SCALE_MAX  = '1;
    localparam diff_t  SPAN_MIN   = 2;
    localparam prod_t  ROUND_BIAS = prod_t'((1 << SCALE_FRAC_BITS) - 1);
    localparam shr_t   CLIP_HI    = shr_t'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam shr_t   CLIP_LO    = -CLIP_HI - shr_t'(1);

    typedef enum logic [CMD_W-1:0] {
        CMD_MEASURE   = 3'd0,
        CMD_CAL_FIRST = 3'd1,
        CMD_CAL       = 3'd2,
        CMD_FINISH    = 3'd3,
        CMD_IDENTITY  = 3'd4
    } cmd_e;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_DEGEN = 2'd1,
        ST_SAT   = 2'd2
    } status_e;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CORR,
        S_FIN,
        S_CHECK,
        S_DIV_GO,
        S_DIV_WAIT,
        S_DONE
    } state_e;

    // Events from the datapath into the sequencer.
    typedef struct packed {
        logic                 fire;
        logic [CMD_W-1:0]     cmd;
        logic                 degen;
        logic                 div_done;
        logic                 out_free;
    } seq_evt_t;

    // Strobes from the sequencer into the datapath.
    typedef struct packed {
        logic   in_ready;
        logic   mul_en;
        logic   corr_en;
        logic   fin_load;
        logic   fin_check;
        logic   div_start;
        logic   scale_wr;
        logic   out_load;
        axis_t  axis;
    } seq_ctl_t;

endpackage

@@ hw/rtl/mmc_if.sv @@
// Valid/ready channel interfaces for sample beats in and result beats out.
// Depends on mmc_pkg.
interface mmc_in_if;
    import mmc_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    sample_t          raw_x;
    sample_t          raw_y;
    sample_t          raw_z;

    modport source (output valid, command, raw_x, raw_y, raw_z, input ready);
    modport sink   (input valid, command, raw_x, raw_y, raw_z, output ready);
endinterface

interface mmc_out_if;
    import mmc_pkg::*;

    logic                valid;
    logic                ready;
    sample_t             corrected_x;
    sample_t             corrected_y;
    sample_t             corrected_z;
    logic [STATUS_W-1:0] status;

    modport source (output valid, corrected_x, corrected_y, corrected_z, status,
                    input ready);
    modport sink   (input valid, corrected_x, corrected_y, corrected_z, status,
                    output ready);
endinterface

@@ hw/rtl/mmc_divider.sv @@
// Restoring divider, one quotient bit per cycle, shared by the three scales.
// Depends on mmc_pkg.
module mmc_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  mmc_pkg::dividend_t dividend,
    input  mmc_pkg::divisor_t  divisor,
    output logic               done,
    output mmc_pkg::quo_t      quotient
);
    import mmc_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    divisor_t              rem_reg;
    divisor_t              dvs_reg;
    quo_t                  quo_reg;

    logic [DIVISOR_W:0]    rem_shift;
    logic                  fits;
    logic [DIVISOR_W:0]    rem_diff;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[QUO_W-1]};
        fits      = rem_shift >= {1'b0, dvs_reg};
        rem_diff  = rem_shift - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(QUO_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract if the divisor fits
            rem_reg <= fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ hw/rtl/mmc_seq.sv @@
// Sequencer of the calibrator: steps the shared multiplier and divider
// over the three axes. Depends on mmc_pkg.
module mmc_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  mmc_pkg::seq_evt_t evt,
    output mmc_pkg::seq_ctl_t ctl
);
    import mmc_pkg::*;

    state_e state_reg;
    state_e state_next;
    axis_t  axis_reg;
    axis_t  axis_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= AXIS_FIRST;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (evt.fire)
                begin
                    axis_next = AXIS_FIRST;
                    priority if (evt.cmd <= CMD_CAL)
                        state_next = S_MUL;
                    else if (evt.cmd == CMD_FINISH)
                        state_next = S_FIN;
                    else
                        state_next = S_DONE;
                end
            end
            S_MUL:
            begin
                state_next = S_CORR;
            end
            S_CORR:
            begin
                if (axis_reg == AXIS_LAST)
                    state_next = S_DONE;
                else
                begin
                    axis_next  = axis_reg + AXIS_W'(1);
                    state_next = S_MUL;
                end
            end
            S_FIN:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = evt.degen ? S_DONE : S_DIV_GO;
            end
            S_DIV_GO:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (evt.div_done)
                begin
                    if (axis_reg == AXIS_LAST)
                        state_next = S_DONE;
                    else
                    begin
                        axis_next  = axis_reg + AXIS_W'(1);
                        state_next = S_DIV_GO;
                    end
                end
            end
            S_DONE:
            begin
                if (evt.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl           = '0;
        ctl.axis      = axis_reg;
        ctl.in_ready  = (state_reg == S_IDLE);
        ctl.mul_en    = (state_reg == S_MUL);
        ctl.corr_en   = (state_reg == S_CORR);
        ctl.fin_load  = (state_reg == S_FIN);
        ctl.fin_check = (state_reg == S_CHECK);
        ctl.div_start = (state_reg == S_DIV_GO);
        ctl.scale_wr  = (state_reg == S_DIV_WAIT) && evt.div_done;
        ctl.out_load  = (state_reg == S_DONE) && evt.out_free;
    end

endmodule

@@ hw/rtl/magnetometer_minmax_calibrator.sv @@
// Magnetometer min/max calibrator: one sample beat in, one result beat out.
// Measure/calibration: each of the 3 axes is multiplied, then corrected, on one
// shared multiplier. Finish: three shared divider passes of 29 quotient bits;
// degenerate range skips them, identity/unused go straight out. No beats overlap.
// A held result stalls the next finished beat until taken, blocking accept.
// rst_n clears control, offsets to zero and scales to one; no clearing pass.
`include "assert_macros.svh"

module magnetometer_minmax_calibrator (
    input  logic             clk,
    input  logic             rst_n,
    mmc_in_if.sink           sample,
    mmc_out_if.source        result
);
    import mmc_pkg::*;

    seq_evt_t  evt;
    seq_ctl_t  ctl;

    sample_t   raw_in [AXES];
    sample_t   raw_reg [AXES];
    sample_t   min_reg [AXES];
    sample_t   max_reg [AXES];
    sample_t   offset_reg [AXES];
    scale_t    scale_reg [AXES];
    half_t     half_reg [AXES];
    sample_t   res_reg [AXES];
    sample_t   out_res_reg [AXES];
    sum_t      sum_reg;
    logic      degen_reg;
    prod_t     prod_reg;
    status_e   status_reg;
    status_e   out_status_reg;
    logic      out_valid_reg;

    diff_t     span [AXES];
    half_t     half_c [AXES];
    sample_t   mid_c [AXES];
    logic      degen_c;
    sum_t      sum_c;

    diff_t     corr_diff;
    sscale_t   corr_scale;
    prod_t     prod_next;
    prod_t     prod_adj;
    shr_t      prod_shr;
    sample_t   clipped;
    logic      clip_hit;

    divisor_t  div_divisor;
    dividend_t div_dividend;
    quo_t      div_quotient;
    logic      div_done;
    scale_t    scale_next;

    logic      fire;
    logic      out_free;

    assign raw_in[0] = sample.raw_x;
    assign raw_in[1] = sample.raw_y;
    assign raw_in[2] = sample.raw_z;

    assign fire     = sample.valid && ctl.in_ready;
    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        evt          = '0;
        evt.fire     = fire;
        evt.cmd      = sample.command;
        evt.degen    = degen_reg;
        evt.div_done = div_done;
        evt.out_free = out_free;
    end

    mmc_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt),
        .ctl   (ctl)
    );

    // Range, half-range and midpoint of each axis, from the stored extremes.
    always_comb
    begin
        diff_t msum;
        diff_t madj;
        degen_c = 1'b0;
        sum_c   = '0;
        for (int a = 0; a < AXES; a++)
        begin
            span[a]   = diff_t'(max_reg[a]) - diff_t'(min_reg[a]);
            half_c[a] = half_t'(span[a] >>> 1);
            msum      = diff_t'(min_reg[a]) + diff_t'(max_reg[a]);
            madj      = msum + diff_t'(msum[DIFF_W-1]);
            mid_c[a]  = sample_t'(madj >>> 1);
            degen_c   = degen_c || (span[a] < SPAN_MIN);
            sum_c     = sum_c + sum_t'(half_c[a]);
        end
    end

    // Shared multiplier: one axis per pass.
    always_comb
    begin
        corr_diff  = diff_t'(raw_reg[ctl.axis]) - diff_t'(offset_reg[ctl.axis]);
        corr_scale = sscale_t'({1'b0, scale_reg[ctl.axis]});
        prod_next  = prod_t'(corr_diff) * prod_t'(corr_scale);
    end

    // Truncate toward zero, then clip to the sample range.
    always_comb
    begin
        prod_adj = prod_reg + (prod_reg[PROD_W-1] ? ROUND_BIAS : prod_t'(0));
        prod_shr = shr_t'(prod_adj >>> SCALE_FRAC_BITS);
        clip_hit = 1'b1;
        priority if (prod_shr > CLIP_HI)
            clipped = sample_t'(CLIP_HI);
        else if (prod_shr < CLIP_LO)
            clipped = sample_t'(CLIP_LO);
        else
        begin
            clipped  = sample_t'(prod_shr);
            clip_hit = 1'b0;
        end
    end

    // Divisor is three times the half-range of the current axis: half + 2*half.
    always_comb
    begin
        div_divisor  = divisor_t'(half_reg[ctl.axis])
                     + (divisor_t'(half_reg[ctl.axis]) << 1);
        div_dividend = {sum_reg, {SCALE_FRAC_BITS{1'b0}}};
        scale_next   = (|div_quotient[QUO_W-1:SCALE_W]) ? SCALE_MAX
                                                        : div_quotient[SCALE_W-1:0];
    end

    mmc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Offsets and scales: identity on reset, command or degenerate finish; else midpoints and divided scales.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                offset_reg[a] <= '0;
                scale_reg[a]  <= SCALE_ONE;
            end
        end
        else if (fire && sample.command == CMD_IDENTITY)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                offset_reg[a] <= '0;
                scale_reg[a]  <= SCALE_ONE;
            end
        end
        else if (ctl.fin_check)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                offset_reg[a] <= degen_reg ? sample_t'(0) : mid_c[a];
                scale_reg[a]  <= SCALE_ONE;
            end
        end
        else if (ctl.scale_wr)
        begin
            scale_reg[ctl.axis] <= scale_next;
        end
    end

    // Extremes, the working sample, the finish terms and the product.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                raw_reg[a] <= raw_in[a];
                if (sample.command == CMD_CAL_FIRST)
                begin
                    min_reg[a] <= raw_in[a];
                    max_reg[a] <= raw_in[a];
                end
                else if (sample.command == CMD_CAL)
                begin
                    if (raw_in[a] < min_reg[a])
                        min_reg[a] <= raw_in[a];
                    if (raw_in[a] > max_reg[a])
                        max_reg[a] <= raw_in[a];
                end
            end
        end
        if (ctl.fin_load)
        begin
            half_reg  <= half_c;
            sum_reg   <= sum_c;
            degen_reg <= degen_c;
        end
        if (ctl.mul_en)
            prod_reg <= prod_next;
    end

    // Working result of the beat in progress.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= ST_OK;
            for (int a = 0; a < AXES; a++)
                res_reg[a] <= '0;
        end
        else if (fire)
        begin
            status_reg <= ST_OK;
            for (int a = 0; a < AXES; a++)
                res_reg[a] <= '0;
        end
        else if (ctl.corr_en)
        begin
            res_reg[ctl.axis] <= clipped;
            if (clip_hit)
                status_reg <= ST_SAT;
        end
        else if (ctl.fin_check && degen_reg)
        begin
            status_reg <= ST_DEGEN;
        end
    end

    // Output register: hold the finished beat until it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.out_load)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            out_res_reg    <= res_reg;
            out_status_reg <= status_reg;
        end
    end

    assign sample.ready       = ctl.in_ready;
    assign result.valid       = out_valid_reg;
    assign result.corrected_x = out_res_reg[0];
    assign result.corrected_y = out_res_reg[1];
    assign result.corrected_z = out_res_reg[2];
    assign result.status      = out_status_reg;

    `MMC_ASSERT(a_busy_after_accept, clk, rst_n, fire |=> !sample.ready, "ready after accept")
    `MMC_ASSERT(a_degen_zero, clk, rst_n, (result.valid && result.status == ST_DEGEN) |-> (result.corrected_x == '0 && result.corrected_y == '0 && result.corrected_z == '0), "degenerate result not zero")
    `MMC_NEVER(a_load_over_full, clk, rst_n, ctl.out_load && out_valid_reg && !result.ready, "result overwritten")

endmodule
